@@ design/fbr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the framed byte receiver with CRC-16 check.
// Used by framed_byte_receiver_crc_check_unit and its port checker.
package fbr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINATOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NACK       = 3'd3;

   localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'h3A;
   localparam logic [BYTE_W-1:0] TERMINATOR_RESET = 8'h0A;
   localparam logic [BYTE_W-1:0] ACK_RESET        = 8'hAA;
   localparam logic [BYTE_W-1:0] NACK_RESET       = 8'hAF;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN_RD,
      ST_LEN,
      ST_FETCH,
      ST_XOR,
      ST_SHIFT,
      ST_HI_RD,
      ST_HI,
      ST_LO,
      ST_RESP
   } state_type;

   function automatic logic [CRC_W-1:0] crc_bit_step(input logic [CRC_W-1:0] crc);
      logic [CRC_W-1:0] shifted;
      shifted = crc >> 1;
      return crc[0] ? (shifted ^ CRC_POLY) : shifted;
   endfunction

endpackage

@@ design/framed_byte_receiver_crc_check_unit.sv @@
`timescale 1ns / 1ps
// Framed byte receiver: frame store, frame delimiting and CRC-16/Modbus check.
// Depends on fbr_pkg for state type, register indexes and CRC constants.
//
// Usage:
//   Request channel (req_valid / req_stall / req_rx_byte) carries one received
//   byte per beat. While idle, a byte equal to the header code opens a frame;
//   every byte of an open frame is stored, and the terminator code closes it.
//   Bytes past the store capacity are dropped; a terminator still closes.
//   Response channel (rsp_valid / rsp_stall / rsp_reply_byte / rsp_frame_good)
//   carries one beat per closed frame: ack or nack code and the match flag.
//   Bytes that do not close a frame are taken without a stall while idle. The
//   closing byte starts a check that one bit-serial CRC unit and the single
//   store read port walk over N bytes (N = stored length byte), each with one
//   store read, one xor and eight shift steps; when N + 2 reaches the store
//   depth the walk is skipped and the reply is a nack. The response holds
//   until taken; req_stall stays high after the closing beat until then.
//   Reset: synchronous, active high; control and CSR registers take defaults;
//   every store entry reads as zero until written. No clearing pass is needed.
//   A stalled response holds its payload and keeps the request side stalled.
//   Configuration writes (csr_*) take effect at once and belong in idle time.
module framed_byte_receiver_crc_check_unit #(
   parameter int STORE_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fbr_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fbr_pkg::BYTE_W-1:0]      rsp_reply_byte,
   output logic                            rsp_frame_good,
   input  logic                            csr_write_enable,
   input  logic [fbr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fbr_pkg::BYTE_W-1:0]      csr_write_data
);
   import fbr_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int PW = $clog2(STORE_DEPTH + 1);
   localparam int LW = 10;
   localparam logic [PW-1:0] POS_FULL = PW'(STORE_DEPTH);
   localparam logic [LW-1:0] LEN_LIMIT = LW'(STORE_DEPTH);

   logic [BYTE_W-1:0] header_ff, terminator_ff, ack_ff, nack_ff;

   state_type state_ff, state_in;
   logic              in_frame_ff, in_frame_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     len_ff, len_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [2:0]        bit_ff, bit_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              hi_ok_ff, hi_ok_in;
   logic [BYTE_W-1:0] reply_ff, reply_in;
   logic              good_ff, good_in;

   logic [BYTE_W-1:0]      mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff;
   logic [BYTE_W-1:0]      rd_data_ff;
   logic                   rd_valid_ff;
   logic [AW-1:0]          rd_addr;
   logic [BYTE_W-1:0]      rd_byte;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;

   logic              req_accept;
   logic              opening;
   logic              frame_live;
   logic [PW-1:0]     pos_eff;
   logic [LW-1:0]     len_plus2;

   assign req_accept = req_valid && !req_stall;
   assign rd_byte    = rd_valid_ff ? rd_data_ff : '0;
   assign len_plus2  = LW'(rd_byte) + LW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= HEADER_RESET;
         terminator_ff <= TERMINATOR_RESET;
         ack_ff        <= ACK_RESET;
         nack_ff       <= NACK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HEADER:     header_ff     <= csr_write_data;
            CSR_TERMINATOR: terminator_ff <= csr_write_data;
            CSR_ACK:        ack_ff        <= csr_write_data;
            CSR_NACK:       nack_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_rx_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      crc_ff   <= crc_in;
      hi_ok_ff <= hi_ok_in;
      reply_ff <= reply_in;
      good_ff  <= good_in;
   end

   always_comb begin
      state_in    = state_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      bit_in      = bit_ff;
      crc_in      = crc_ff;
      hi_ok_in    = hi_ok_ff;
      reply_in    = reply_ff;
      good_in     = good_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      wr_en       = 1'b0;
      rd_addr     = '0;
      opening     = !in_frame_ff && (req_rx_byte == header_ff);
      frame_live  = in_frame_ff || opening;
      pos_eff     = opening ? '0 : pos_ff;
      wr_addr     = pos_eff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && frame_live) begin
               in_frame_in = 1'b1;
               pos_in      = pos_eff;
               if (pos_eff < POS_FULL) begin
                  wr_en = 1'b1;
               end
               if (req_rx_byte == terminator_ff) begin
                  in_frame_in = 1'b0;
                  pos_in      = '0;
                  state_in    = ST_LEN_RD;
               end else if (pos_eff < POS_FULL) begin
                  pos_in = pos_eff + PW'(1);
               end
            end
         end
         ST_LEN_RD: begin
            rd_addr  = AW'(2);
            state_in = ST_LEN;
         end
         ST_LEN: begin
            len_in = rd_byte[AW-1:0];
            crc_in = CRC_INIT;
            idx_in = AW'(1);
            if (len_plus2 >= LEN_LIMIT) begin
               reply_in = nack_ff;
               good_in  = 1'b0;
               state_in = ST_RESP;
            end else if (rd_byte == '0) begin
               state_in = ST_HI_RD;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_addr  = idx_ff;
            state_in = ST_XOR;
         end
         ST_XOR: begin
            crc_in   = crc_ff ^ CRC_W'(rd_byte);
            bit_in   = '0;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            crc_in = crc_bit_step(crc_ff);
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               if (idx_ff == len_ff) begin
                  state_in = ST_HI_RD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_HI_RD: begin
            rd_addr  = len_ff + AW'(1);
            state_in = ST_HI;
         end
         ST_HI: begin
            rd_addr  = len_ff + AW'(2);
            hi_ok_in = (rd_byte == crc_ff[CRC_W-1:BYTE_W]);
            state_in = ST_LO;
         end
         ST_LO: begin
            good_in  = hi_ok_ff && (rd_byte == crc_ff[BYTE_W-1:0]);
            reply_in = (hi_ok_ff && (rd_byte == crc_ff[BYTE_W-1:0])) ? ack_ff : nack_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_reply_byte = reply_ff;
   assign rsp_frame_good = good_ff;

endmodule

@@ design/fbr_port_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for framed_byte_receiver_crc_check_unit, bound to the top.
// Depends on fbr_pkg for port widths.
module fbr_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [fbr_pkg::BYTE_W-1:0] rsp_reply_byte,
   input logic                       rsp_frame_good
);
   import fbr_pkg::*;

   // hold a stalled response beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply_byte)
         && $stable(rsp_frame_good))
      else $error("stalled response beat changed");

   // no request beat while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   // one response beat per frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("response repeated");

   // check never finishes in the cycle after a request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response too early");

endmodule

bind framed_byte_receiver_crc_check_unit fbr_port_checker u_fbr_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_reply_byte (rsp_reply_byte),
   .rsp_frame_good (rsp_frame_good)
);
